### sv/utf_stream_transcoder_defines.svh
// ---------------------------------------------------------------------------
// utf_stream_transcoder_defines.svh
// Assertion macros shared by the transcoder RTL.
// ---------------------------------------------------------------------------
`ifndef UTF_STREAM_TRANSCODER_DEFINES_SVH
`define UTF_STREAM_TRANSCODER_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_IMPL(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication
`define ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, pre, post)
`define ASSERT_NEXT(label, pre, post)
`endif

`endif

### sv/ust_pkg.sv
// ---------------------------------------------------------------------------
// ust_pkg
// Types and constants shared by the UTF stream transcoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package ust_pkg;

  // format codes
  localparam logic [1:0] FMT_UTF32 = 2'd0;
  localparam logic [1:0] FMT_UTF16 = 2'd1;
  localparam logic [1:0] FMT_UTF8  = 2'd2;
  localparam logic [1:0] FMT_NONE  = 2'd3;  // undefined code, words are dropped

  // configuration register indexes
  localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
  localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
  localparam logic [1:0] REG_STOP_ON_ZERO  = 2'd2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 2;

  typedef struct packed {
    logic [1:0] source_format;
    logic [1:0] target_format;
    logic       stop_on_zero;
  } cfg_t;

  // one decoded character plus terminator info, front to back
  typedef struct packed {
    logic [31:0] ch;
    logic        enc;   // ch is to be encoded
    logic        term;  // emit terminator after it
    logic        err;   // terminator is an error stop
  } rec_t;

endpackage

`default_nettype wire

### sv/ust_front.sv
// ---------------------------------------------------------------------------
// ust_front
// Source decoder: assembles UTF-8 / UTF-16 sequences, detects stops and
// pushes one character record per word that causes output.
// ---------------------------------------------------------------------------
`default_nettype none

module ust_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ust_pkg::cfg_t cfg,
  input  wire logic        cfg_clear,
  input  wire logic        accept,
  input  wire logic [31:0] code_unit,
  input  wire logic        end_of_input,
  output logic             push,
  output ust_pkg::rec_t    rec
);

  logic [20:0] partial_char;
  logic [20:0] partial_char_next;
  logic [1:0]  units_pending;
  logic [1:0]  units_pending_next;
  logic        halted;
  logic        halted_next;

  logic        bad_fmt;
  logic        have;
  logic        err;
  logic        stop;
  logic        term;
  logic [31:0] ch;
  logic [15:0] u16;
  logic [7:0]  b8;
  logic [20:0] pair_val;
  logic [20:0] cont_val;

  assign u16      = code_unit[15:0];
  assign b8       = code_unit[7:0];
  assign pair_val = {1'b0, partial_char[9:0], u16[9:0]} + 21'h010000;
  assign cont_val = {partial_char[14:0], b8[5:0]};
  assign bad_fmt  = (cfg.source_format == ust_pkg::FMT_NONE) ||
                    (cfg.target_format == ust_pkg::FMT_NONE);

  always_comb begin
    partial_char_next  = partial_char;
    units_pending_next = units_pending;
    halted_next        = halted;
    have = 1'b0;
    err  = 1'b0;
    stop = 1'b0;
    term = 1'b0;
    ch   = '0;
    push = 1'b0;
    if (bad_fmt) begin
      partial_char_next  = '0;
      units_pending_next = '0;
      halted_next        = 1'b0;
    end else if (halted) begin
      if (end_of_input) halted_next = 1'b0;
    end else begin
      case (cfg.source_format)
        ust_pkg::FMT_UTF32: begin
          ch   = code_unit;
          have = 1'b1;
        end
        ust_pkg::FMT_UTF16: begin
          if (units_pending != 2'd0) begin
            if (u16 inside {[16'hDC00:16'hDFFF]}) begin
              ch   = {11'd0, pair_val};
              have = 1'b1;
              units_pending_next = '0;
              partial_char_next  = '0;
            end else begin
              err = 1'b1;
            end
          end else if (u16 inside {[16'hD800:16'hDBFF]}) begin
            partial_char_next  = {11'd0, u16[9:0]};
            units_pending_next = 2'd1;
          end else begin
            ch   = {16'd0, u16};
            have = 1'b1;
          end
        end
        default: begin
          if (units_pending != 2'd0) begin
            if (b8[7:6] == 2'b10) begin
              units_pending_next = units_pending - 2'd1;
              if (units_pending == 2'd1) begin
                ch   = {11'd0, cont_val};
                have = 1'b1;
                partial_char_next = '0;
              end else begin
                partial_char_next = cont_val;
              end
            end else begin
              err = 1'b1;
            end
          end else if (b8[7] == 1'b0) begin
            ch   = {25'd0, b8[6:0]};
            have = 1'b1;
          end else if (b8[7:5] == 3'b110) begin
            partial_char_next  = {16'd0, b8[4:0]};
            units_pending_next = 2'd1;
          end else if (b8[7:4] == 4'b1110) begin
            partial_char_next  = {17'd0, b8[3:0]};
            units_pending_next = 2'd2;
          end else if (b8[7:3] == 5'b11110) begin
            partial_char_next  = {18'd0, b8[2:0]};
            units_pending_next = 2'd3;
          end else begin
            err = 1'b1;
          end
        end
      endcase

      stop = have && cfg.stop_on_zero && (ch == 32'd0);
      // cut off mid-sequence at the last word
      if (!stop && !err && end_of_input && (units_pending_next != 2'd0)) err = 1'b1;
      term = err || stop || end_of_input;
      if (term) begin
        partial_char_next  = '0;
        units_pending_next = '0;
        halted_next        = !end_of_input;
      end
      push = accept && ((have && !stop) || term);
    end
  end

  always_comb begin
    rec.ch   = ch;
    rec.enc  = have && !stop;
    rec.term = term;
    rec.err  = err;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      partial_char  <= '0;
      units_pending <= '0;
      halted        <= 1'b0;
    end else if (accept) begin
      partial_char  <= partial_char_next;
      units_pending <= units_pending_next;
      halted        <= halted_next;
    end
  end

endmodule

`default_nettype wire

### sv/ust_queue.sv
// ---------------------------------------------------------------------------
// ust_queue
// Short record FIFO between the decoder and the encoder.
// ---------------------------------------------------------------------------
`default_nettype none

module ust_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ust_pkg::rec_t wr_rec,
  input  wire logic          pop,
  output ust_pkg::rec_t      rd_rec,
  output logic               full,
  output logic               empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  ust_pkg::rec_t      entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full   = (count == CNT_W'(DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr] <= wr_rec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/ust_back.sv
// ---------------------------------------------------------------------------
// ust_back
// Target encoder: walks the head record one destination word per cycle,
// while the output is not stalled, into the output register, terminator last.
// ---------------------------------------------------------------------------
`default_nettype none

module ust_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [1:0]    target_format,
  input  wire ust_pkg::rec_t head,
  input  wire logic          head_valid,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [31:0]        out_unit,
  output logic               is_terminator,
  output logic               stopped_on_error
);

  logic [2:0]  idx;
  logic [2:0]  idx_next;
  logic [2:0]  n_enc;
  logic [2:0]  total;
  logic        load;
  logic        last_word;
  logic [31:0] units [4];
  logic [31:0] ch;
  logic [31:0] v;

  assign ch = head.ch;
  assign v  = ch - 32'h0001_0000;

  always_comb begin
    n_enc = 3'd0;
    for (int k = 0; k < 4; k++) units[k] = 32'd0;
    if (head.enc) begin
      case (target_format)
        ust_pkg::FMT_UTF32: begin
          n_enc    = 3'd1;
          units[0] = ch;
        end
        ust_pkg::FMT_UTF16: begin
          if (ch > 32'h0000_FFFF) begin
            n_enc    = 3'd2;
            units[0] = {16'd0, 6'b110110, v[19:10]};
            units[1] = {16'd0, 6'b110111, ch[9:0]};
          end else begin
            n_enc    = 3'd1;
            units[0] = ch;
          end
        end
        default: begin
          if (ch <= 32'h0000_007F) begin
            n_enc    = 3'd1;
            units[0] = ch;
          end else if (ch <= 32'h0000_07FF) begin
            n_enc    = 3'd2;
            units[0] = {24'd0, 3'b110, ch[10:6]};
            units[1] = {24'd0, 2'b10, ch[5:0]};
          end else if (ch <= 32'h0000_FFFF) begin
            n_enc    = 3'd3;
            units[0] = {24'd0, 4'b1110, ch[15:12]};
            units[1] = {24'd0, 2'b10, ch[11:6]};
            units[2] = {24'd0, 2'b10, ch[5:0]};
          end else if (ch <= 32'h0010_FFFF) begin
            n_enc    = 3'd4;
            units[0] = {24'd0, 5'b11110, ch[20:18]};
            units[1] = {24'd0, 2'b10, ch[17:12]};
            units[2] = {24'd0, 2'b10, ch[11:6]};
            units[3] = {24'd0, 2'b10, ch[5:0]};
          end
          // above the UTF-8 range: nothing encoded
        end
      endcase
    end
  end

  assign total     = n_enc + {2'd0, head.term};
  assign load      = !out_valid || out_ready;
  assign last_word = (total == 3'd0) || (idx == total - 3'd1);
  assign pop       = load && head_valid && last_word;

  always_comb begin
    idx_next = idx;
    if (load && head_valid) idx_next = last_word ? 3'd0 : idx + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (load) out_valid <= head_valid && (total != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      if (idx < n_enc) begin
        out_unit         <= units[idx[1:0]];
        is_terminator    <= 1'b0;
        stopped_on_error <= 1'b0;
      end else begin
        out_unit         <= 32'd0;
        is_terminator    <= 1'b1;
        stopped_on_error <= head.err;
      end
    end
  end

endmodule

`default_nettype wire

### sv/utf_stream_transcoder.sv
// ---------------------------------------------------------------------------
// utf_stream_transcoder
// UTF-8 / UTF-16 / UTF-32 stream transcoder, top level.
// ---------------------------------------------------------------------------
// The block takes one source word per cycle on s_* while s_tready is high
// and, through a QUEUE_DEPTH record queue, emits destination words on m_*
// at one word per cycle while m_tready is high. A source word completing a
// character yields as many words as it has target words (up to four for
// UTF-8) plus a terminator if its record ends the string; the encoder walking
// those words one per cycle sets the sustained rate, so single-word output
// runs at one word per cycle and s_tready drops only when the queue fills.
// The terminator is a zero word with m_tlast set; m_tuser marks an error
// stop. Write configuration only while the block is idle; any write to a
// defined register restarts the string.
`default_nettype none
`include "utf_stream_transcoder_defines.svh"

module utf_stream_transcoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // s_tdata: [31:0] code_unit
  input  wire logic [31:0] s_tdata,
  input  wire logic        s_tlast,   // end_of_input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // m_tdata: [31:0] out_unit
  output logic [31:0]      m_tdata,
  output logic             m_tlast,   // is_terminator
  // m_tuser: [0] stopped_on_error
  output logic [0:0]       m_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  input  wire logic                          cfg_we,
  input  wire logic [ust_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ust_pkg::CFG_DATA_W-1:0] cfg_data
);

  ust_pkg::cfg_t cfg;
  ust_pkg::rec_t f_rec;
  ust_pkg::rec_t q_head;
  logic          cfg_clear;
  logic          f_push;
  logic          q_full;
  logic          q_empty;
  logic          b_pop;
  logic          accept;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign cfg_clear = cfg_we && ((cfg_addr == ust_pkg::REG_SOURCE_FORMAT) ||
                                (cfg_addr == ust_pkg::REG_TARGET_FORMAT) ||
                                (cfg_addr == ust_pkg::REG_STOP_ON_ZERO));

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_format <= ust_pkg::FMT_UTF8;
      cfg.target_format <= ust_pkg::FMT_UTF32;
      cfg.stop_on_zero  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ust_pkg::REG_SOURCE_FORMAT: cfg.source_format <= cfg_data[1:0];
        ust_pkg::REG_TARGET_FORMAT: cfg.target_format <= cfg_data[1:0];
        ust_pkg::REG_STOP_ON_ZERO:  cfg.stop_on_zero  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ust_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .cfg_clear    (cfg_clear),
    .accept       (accept),
    .code_unit    (s_tdata),
    .end_of_input (s_tlast),
    .push         (f_push),
    .rec          (f_rec)
  );

  ust_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (f_push),
    .wr_rec (f_rec),
    .pop    (b_pop),
    .rd_rec (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  ust_back u_back (
    .clk              (clk),
    .rst              (rst),
    .target_format    (cfg.target_format),
    .head             (q_head),
    .head_valid       (!q_empty),
    .pop              (b_pop),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_unit         (m_tdata),
    .is_terminator    (m_tlast),
    .stopped_on_error (m_tuser[0])
  );

  // error mark only ever rides on a terminator
  `ASSERT_IMPL(a_err_on_term, m_tvalid && m_tuser[0], m_tlast)
  // terminator word is zero in every target format
  `ASSERT_IMPL(a_term_zero, m_tvalid && m_tlast, m_tdata == 32'd0)
  // UTF-8 target emits bytes only
  `ASSERT_IMPL(a_utf8_byte, m_tvalid && (cfg.target_format == ust_pkg::FMT_UTF8),
               m_tdata[31:8] == 24'd0)
  // output register loads only from a queued record
  `ASSERT_NEXT(a_no_word_from_empty, q_empty && (!m_tvalid || m_tready), !m_tvalid)

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF stream transcoder. A short table of
// directed words covers the encoding edges and the error stops. Random runs
// of well-formed and broken characters follow, under every pair of source
// and target formats. A local model of the transcoder predicts each output
// word, and a monitor compares every word the block emits against it.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam logic [1:0] REG_SPARE = 2'd3;  // index with no register behind it
  localparam int IDLE_TAIL   = 12;
  localparam int LONG_HOLD   = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] unit;
    logic        term;
    logic        err;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  src;
    logic [1:0]  dst;
    logic [1:0]  zs;
    logic [31:0] unit;
    logic        last;
    logic        typed;
    out_word_t   want;
  } vec_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic [31:0]                    s_tdata = '0;
  logic                           s_tlast = 1'b0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [31:0]                    m_tdata;
  logic                           m_tlast;
  logic [0:0]                     m_tuser;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [ust_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [ust_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // transcoder model state
  logic [1:0]  cur_src = ust_pkg::FMT_UTF8;
  logic [1:0]  cur_dst = ust_pkg::FMT_UTF32;
  logic        cur_zs = 1'b0;
  logic [20:0] partial = '0;
  logic [1:0]  pending = '0;
  logic        halt = 1'b0;

  out_word_t dest_units_q[$];
  vec_t      dir_q[$];

  int  mismatches = 0;
  int  words_seen = 0;
  int  words_predicted = 0;
  int  units_sent = 0;
  int  phases_run = 0;
  int  quiet = 0;
  bit  src_idle_on = 1'b1;
  bit  sink_idle_on = 1'b1;
  bit  long_hold = 1'b0;

  utf_stream_transcoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [1:0] fmt_of(input int i);
    case (i)
      0:       return ust_pkg::FMT_UTF32;
      1:       return ust_pkg::FMT_UTF16;
      default: return ust_pkg::FMT_UTF8;
    endcase
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
  endfunction

  function automatic void check_word(input string tag, input out_word_t want,
                                     input out_word_t got);
    if (want !== got)
      flag_mismatch($sformatf("%s: expected unit %h term %b err %b, got unit %h term %b err %b",
                              tag, want.unit, want.term, want.err,
                              got.unit, got.term, got.err));
  endfunction

  task automatic put_word(input logic [31:0] unit, input logic term, input logic err);
    dest_units_q.push_back({unit, term, err});
    words_predicted++;
  endtask

  task automatic encode_char(input logic [31:0] c);
    logic [31:0] v;
    v = c - 32'h10000;
    case (cur_dst)
      ust_pkg::FMT_UTF32: put_word(c, 1'b0, 1'b0);
      ust_pkg::FMT_UTF16: begin
        if (c > 32'hFFFF) begin
          put_word(32'hD800 | ((v >> 10) & 32'h3FF), 1'b0, 1'b0);
          put_word(32'hDC00 | (v & 32'h3FF), 1'b0, 1'b0);
        end else begin
          put_word(c, 1'b0, 1'b0);
        end
      end
      ust_pkg::FMT_UTF8: begin
        if (c <= 32'h7F) begin
          put_word(c, 1'b0, 1'b0);
        end else if (c <= 32'h7FF) begin
          put_word(32'hC0 | c[10:6], 1'b0, 1'b0);
          put_word(32'h80 | c[5:0], 1'b0, 1'b0);
        end else if (c <= 32'hFFFF) begin
          put_word(32'hE0 | c[15:12], 1'b0, 1'b0);
          put_word(32'h80 | c[11:6], 1'b0, 1'b0);
          put_word(32'h80 | c[5:0], 1'b0, 1'b0);
        end else if (c <= 32'h10FFFF) begin
          put_word(32'hF0 | c[20:18], 1'b0, 1'b0);
          put_word(32'h80 | c[17:12], 1'b0, 1'b0);
          put_word(32'h80 | c[11:6], 1'b0, 1'b0);
          put_word(32'h80 | c[5:0], 1'b0, 1'b0);
        end
        // beyond the Unicode range: nothing
      end
      default: ;
    endcase
  endtask

  // advance the model by one accepted source word
  task automatic transcode_unit(input logic [31:0] unit, input logic last);
    logic        have;
    logic        err;
    logic        stop;
    logic [31:0] c;
    logic [15:0] u;
    logic [7:0]  b;
    have = 1'b0;
    err  = 1'b0;
    stop = 1'b0;
    c    = '0;
    u    = unit[15:0];
    b    = unit[7:0];
    if (cur_src == ust_pkg::FMT_NONE || cur_dst == ust_pkg::FMT_NONE) begin
      partial = '0;
      pending = '0;
      halt = 1'b0;
    end else if (halt) begin
      if (last) halt = 1'b0;
    end else begin
      case (cur_src)
        ust_pkg::FMT_UTF32: begin
          c = unit;
          have = 1'b1;
        end
        ust_pkg::FMT_UTF16: begin
          if (pending != 2'd0) begin
            if (u >= 16'hDC00 && u <= 16'hDFFF) begin
              c = {12'b0, partial[9:0], u[9:0]} + 32'h10000;
              have = 1'b1;
              pending = '0;
              partial = '0;
            end else begin
              err = 1'b1;  // high surrogate not followed by a low one
            end
          end else if (u >= 16'hD800 && u <= 16'hDBFF) begin
            partial = {11'b0, u[9:0]};
            pending = 2'd1;
          end else begin
            c = {16'b0, u};
            have = 1'b1;
          end
        end
        default: begin
          if (pending != 2'd0) begin
            if (b[7:6] == 2'b10) begin
              partial = {partial[14:0], b[5:0]};
              pending = pending - 2'd1;
              if (pending == 2'd0) begin
                c = {11'b0, partial};
                have = 1'b1;
                partial = '0;
              end
            end else begin
              err = 1'b1;
            end
          end else if (!b[7]) begin
            c = {25'b0, b[6:0]};
            have = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            partial = {16'b0, b[4:0]};
            pending = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            partial = {17'b0, b[3:0]};
            pending = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            partial = {18'b0, b[2:0]};
            pending = 2'd3;
          end else begin
            err = 1'b1;
          end
        end
      endcase

      if (have) begin
        if (cur_zs && c == 32'd0) stop = 1'b1;
        else encode_char(c);
      end
      // string cut short at the end of the buffer
      if (!stop && !err && last && pending != 2'd0) err = 1'b1;
      if (err || stop || last) begin
        put_word(32'd0, 1'b1, err);
        partial = '0;
        pending = '0;
        halt = !last;
      end
    end
  endtask

  task automatic send_unit(input logic [31:0] unit, input logic last);
    int gap;
    gap = src_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= unit;
    s_tlast  <= last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    transcode_unit(unit, last);
    units_sent++;
  endtask

  task automatic drain_stream();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (dest_units_q.size() != 0 || long_hold) @(posedge clk);
    // words that produce nothing may still be in flight
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    case (idx)
      ust_pkg::REG_SOURCE_FORMAT: cur_src = val;
      ust_pkg::REG_TARGET_FORMAT: cur_dst = val;
      ust_pkg::REG_STOP_ON_ZERO:  cur_zs  = val[0];
      default: ;
    endcase
    if (idx != REG_SPARE) begin
      partial = '0;
      pending = '0;
      halt = 1'b0;
    end
  endtask

  task automatic set_format(input logic [1:0] src, input logic [1:0] dst,
                            input logic [1:0] zs);
    write_reg(ust_pkg::REG_SOURCE_FORMAT, src);
    write_reg(ust_pkg::REG_TARGET_FORMAT, dst);
    write_reg(ust_pkg::REG_STOP_ON_ZERO, zs);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] random_code_point();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6)  return 32'd0;
    if (r < 35) return $urandom_range(1, 'h7F);
    if (r < 55) return $urandom_range('h80, 'h7FF);
    if (r < 75) return $urandom_range('h800, 'hFFFF);
    if (r < 92) return $urandom_range('h10000, 'h10FFFF);
    return $urandom_range('h110000, 'h1FFFFF);
  endfunction

  // one character in the current source format, mostly well formed
  task automatic send_random_char(output int sent);
    logic [31:0] cp;
    logic [31:0] v;
    logic [31:0] junk;
    logic [31:0] seq[$];
    int          r;
    bit          end_str;
    bit          last;
    r  = $urandom_range(0, 99);
    cp = random_code_point();
    case (cur_src)
      ust_pkg::FMT_UTF32: seq.push_back(r < 85 ? cp : $urandom());
      ust_pkg::FMT_UTF16: begin
        if (cp > 32'h10FFFF) cp = {16'b0, cp[15:0]};
        if (r < 85) begin
          if (cp > 32'hFFFF) begin
            v = cp - 32'h10000;
            seq.push_back(32'hD800 | v[19:10]);
            seq.push_back(32'hDC00 | v[9:0]);
          end else begin
            seq.push_back(cp);
          end
        end else if (r < 93) begin
          seq.push_back(32'hD800 | $urandom_range(0, 1023));
          seq.push_back($urandom_range(0, 65535));
        end else begin
          seq.push_back($urandom_range(0, 65535));
        end
      end
      default: begin
        if (r < 93) begin
          if (cp <= 32'h7F) begin
            seq.push_back(cp);
          end else if (cp <= 32'h7FF) begin
            seq.push_back(32'hC0 | cp[10:6]);
            seq.push_back(32'h80 | cp[5:0]);
          end else if (cp <= 32'hFFFF) begin
            seq.push_back(32'hE0 | cp[15:12]);
            seq.push_back(32'h80 | cp[11:6]);
            seq.push_back(32'h80 | cp[5:0]);
          end else begin
            seq.push_back(32'hF0 | cp[20:18]);
            seq.push_back(32'h80 | cp[17:12]);
            seq.push_back(32'h80 | cp[11:6]);
            seq.push_back(32'h80 | cp[5:0]);
          end
          // truncated sequence
          if (r >= 85 && seq.size() > 1) void'(seq.pop_back());
        end else begin
          seq.push_back($urandom_range(0, 255));
        end
      end
    endcase
    end_str = ($urandom_range(0, 7) == 0);
    for (int k = 0; k < seq.size(); k++) begin
      // bits above the unit width are don't-care for narrow sources
      junk = '0;
      if (cur_src != ust_pkg::FMT_UTF32 && $urandom_range(0, 3) == 0)
        junk = $urandom() &
               (cur_src == ust_pkg::FMT_UTF16 ? 32'hFFFF_0000 : 32'hFFFF_FF00);
      last = (k == seq.size() - 1) ? end_str : ($urandom_range(0, 49) == 0);
      send_unit(seq[k] | junk, last);
    end
    sent = seq.size();
  endtask

  task automatic add_row(input logic [1:0] src, input logic [1:0] dst, input logic [1:0] zs,
                         input logic [31:0] unit, input logic last,
                         input logic typed, input out_word_t want);
    dir_q.push_back({src, dst, zs, unit, last, typed, want});
  endtask

  // output monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      words_seen++;
      if (dest_units_q.size() == 0)
        flag_mismatch($sformatf("unexpected word unit %h term %b err %b",
                                m_tdata, m_tlast, m_tuser[0]));
      else
        check_word("output", dest_units_q.pop_front(), {m_tdata, m_tlast, m_tuser[0]});
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet = 0;
    end else begin
      quiet = quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // output side ready, with random stalls and one long hold-off
  initial begin : sink_drive
    int stall;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else begin
        stall = sink_idle_on ? pick_gap() : 0;
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
        m_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    vec_t       row;
    int         pred_mark;
    int         n;
    int         quota;
    int         sent;
    logic [1:0] s;
    logic [1:0] d;
    logic [1:0] zv;

    // UTF-8 to UTF-32, the reset setting
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'h00, 1'b0, 1'b1,
            {32'h0, 1'b0, 1'b0});
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hFFFF_FF7F, 1'b0, 1'b1,
            {32'h7F, 1'b0, 1'b0});
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hC3, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hA9, 1'b0, 1'b1,
            {32'hE9, 1'b0, 1'b0});
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hE2, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'h82, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hAC, 1'b0, 1'b0, '0);
    // F7 lead: largest value the four-byte form can carry
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hF7, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hBF, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hBF, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hBF, 1'b0, 1'b0, '0);
    // bad lead stops, then words are dropped up to the last one
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hFF, 1'b0, 1'b1,
            {32'h0, 1'b1, 1'b1});
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'h41, 1'b1, 1'b0, '0);
    // truncated at end of buffer
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF32, 2'd0, 32'hC3, 1'b1, 1'b1,
            {32'h0, 1'b1, 1'b1});
    // string mode: zero ends the string
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF8, 2'd1, 32'h00, 1'b0, 1'b1,
            {32'h0, 1'b1, 1'b0});
    add_row(ust_pkg::FMT_UTF8, ust_pkg::FMT_UTF8, 2'd1, 32'h55, 1'b1, 1'b0, '0);
    // surrogate pair, lone low half, broken pair
    add_row(ust_pkg::FMT_UTF16, ust_pkg::FMT_UTF8, 2'd0, 32'hD83D, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF16, ust_pkg::FMT_UTF8, 2'd0, 32'hDE00, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF16, ust_pkg::FMT_UTF8, 2'd0, 32'hDC00, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF16, ust_pkg::FMT_UTF8, 2'd0, 32'hD800, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF16, ust_pkg::FMT_UTF8, 2'd0, 32'h0041, 1'b0, 1'b1,
            {32'h0, 1'b1, 1'b1});
    // oversized values to UTF-16 keep 10 bits per half
    add_row(ust_pkg::FMT_UTF32, ust_pkg::FMT_UTF16, 2'd0, 32'hFFFF_FFFF, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF32, ust_pkg::FMT_UTF16, 2'd0, 32'h0, 1'b1, 1'b0, '0);
    // beyond U+10FFFF gives no UTF-8 bytes
    add_row(ust_pkg::FMT_UTF32, ust_pkg::FMT_UTF8, 2'd0, 32'h11_0000, 1'b0, 1'b0, '0);
    add_row(ust_pkg::FMT_UTF32, ust_pkg::FMT_UTF8, 2'd0, 32'h10_FFFF, 1'b1, 1'b0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_q[i]) begin
      row = dir_q[i];
      if (row.src != cur_src || row.dst != cur_dst || row.zs[0] != cur_zs) begin
        drain_stream();
        set_format(row.src, row.dst, row.zs);
      end
      pred_mark = words_predicted;
      send_unit(row.unit, row.last);
      if (row.typed) begin
        if (words_predicted - pred_mark != 1)
          flag_mismatch($sformatf("directed row %0d: %0d words predicted, one typed",
                                  i, words_predicted - pred_mark));
        else
          check_word($sformatf("directed row %0d", i), row.want, dest_units_q[$]);
      end
    end

    for (int p = 0; p < 13; p++) begin
      if (p < 9) begin
        s  = fmt_of(p / 3);
        d  = fmt_of(p % 3);
        zv = 2'(p % 2);
      end else begin
        s  = fmt_of($urandom_range(0, 2));
        d  = fmt_of($urandom_range(0, 2));
        zv = 2'($urandom_range(0, 3));
      end
      if (p == 10) s = ust_pkg::FMT_NONE;
      if (p == 11) d = ust_pkg::FMT_NONE;
      drain_stream();
      if (p == 12) write_reg(REG_SPARE, 2'($urandom_range(0, 3)));
      set_format(s, d, zv);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      // UTF-32 into UTF-8 expands the most: stall the output and keep feeding
      if (p == 2) begin
        long_hold = 1'b1;
        src_idle_on = 1'b0;
      end
      quota = (s == ust_pkg::FMT_NONE || d == ust_pkg::FMT_NONE) ? 8 : 30;
      n = 0;
      while (n < quota) begin
        send_random_char(sent);
        n += sent;
      end
      phases_run++;
    end
    drain_stream();

    $display("%0d source words over %0d random phases, %0d output words compared",
             units_sent, phases_run, words_seen);
    $display("all format pairs, string mode, undefined format codes and a long output stall");
    if (mismatches == 0 && dest_units_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### sim.f
+incdir+sv
sv/ust_pkg.sv
sv/ust_front.sv
sv/ust_queue.sv
sv/ust_back.sv
sv/utf_stream_transcoder.sv
tb/sv/testbench.sv
